// ===== rtl/core/vrt_pkg.sv =====
// Shared types, codes and helpers for the video receiver tuner frame control.
// No dependencies; imported by every module in rtl/core.
package vrt_pkg;

    localparam int unsigned AddrWidth = 4;
    localparam int unsigned DataWidth = 32;

    localparam logic [15:0] FreqBase      = 16'd479;
    localparam logic [19:0] PwrDownBits   = 20'hFFFFF;
    localparam logic [19:0] PwrSetupBits  = 20'hD0DF3;
    localparam logic [15:0] BusGapReset   = 16'd30;
    localparam logic [15:0] TuneWaitReset = 16'd35;
    localparam logic [12:0] PwrDownReset  = 13'd1;

    typedef enum logic [1:0] {
        REG_BUS_GAP   = 2'd0,
        REG_TUNE_WAIT = 2'd1,
        REG_PWR_DOWN  = 2'd2
    } vrt_reg_idx_t;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_READBACK = 2'd1,
        KIND_RSSI     = 2'd2
    } vrt_kind_t;

    typedef enum logic [1:0] {
        RES_FRAME  = 2'd0,
        RES_VERIFY = 2'd1,
        RES_RSSI   = 2'd2
    } vrt_res_type_t;

    localparam logic [3:0] AddrFreq  = 4'd1;
    localparam logic [3:0] AddrPower = 4'd10;
    localparam logic [3:0] AddrReset = 4'd15;

    typedef struct packed {
        logic [15:0] bus_gap_ms;
        logic [15:0] tune_wait_ms;
        logic [12:0] power_down_mhz;
    } vrt_cfg_t;

    typedef struct packed {
        logic [1:0]  result_type;
        logic [3:0]  frame_address;
        logic        frame_write;
        logic [19:0] frame_data;
        logic        verify_ok;
        logic [7:0]  rssi_level;
    } vrt_result_t;

    // Up to three results from one request, slot 0 delivered first.
    typedef struct packed {
        logic [1:0]             count;
        vrt_result_t [2:0]      item;
    } vrt_burst_t;

    // Synthesizer N/A word: tf = (f - 479) >> 1, N in bits 15:7, A in bits 4:0.
    function automatic logic [15:0] freq_reg_value(input logic [12:0] mhz);
        logic [15:0] diff;
        logic [14:0] tf;
        diff = {3'b000, mhz} - FreqBase;
        tf   = diff[15:1];
        return {tf[13:5], 2'b00, tf[4:0]};
    endfunction

endpackage

// ===== rtl/core/video_rx_tuner_frame_control.sv =====
// Video receiver tuner frame control: top level.
// Instantiates vrt_cfg_regs, vrt_tick_engine and vrt_result_queue; uses vrt_pkg.
//
// Usage:
//   Requests enter on the s_ channel (valid/ready): a tick with time and wanted
//   frequency, a synthesizer readback word, or an RSSI sample. Results leave on
//   the m_ channel one per cycle while m_ready is high: serial frames for a
//   downstream shifter, verify outcomes, or RSSI levels; m_last_of_run marks
//   a request's final result. Latency: the first result of a request is valid
//   the cycle after acceptance. Throughput: one request per cycle while each
//   yields at most one result and m_ready is high; a wake-from-power-down tick
//   yields three frames and holds s_ready low until the output register has
//   drained all but the last. A request that yields no result loads nothing.
//   Stalls: while m_ready is low the pending result holds and s_ready drops
//   once no more room remains.
//   Reset (aresetn low, synchronous): tuner state clears, registers return to
//   bus gap 30 ms, tune wait 35 ms, power-down frequency 1; no result pending.
//   The user must write configuration via the APB port only while idle; unenforced.
module video_rx_tuner_frame_control (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vrt_pkg::AddrWidth-1:0]  paddr,
    input  logic [vrt_pkg::DataWidth-1:0]  pwdata,
    output logic [vrt_pkg::DataWidth-1:0]  prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_kind,
    input  logic [31:0]                    s_time_ms,
    input  logic [12:0]                    s_requested_mhz,
    input  logic [15:0]                    s_readback_word,
    input  logic [11:0]                    s_rssi_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_result_type,
    output logic [3:0]                     m_frame_address,
    output logic                           m_frame_write,
    output logic [19:0]                    m_frame_data,
    output logic                           m_verify_ok,
    output logic [7:0]                     m_rssi_level,
    output logic                           m_last_of_run
);
    import vrt_pkg::*;

    vrt_cfg_t    cfg;
    vrt_burst_t  burst;
    vrt_result_t head;
    logic        accept, can_load, load;

    assign s_ready = can_load;
    assign accept  = s_valid && s_ready;
    assign load    = accept && (burst.count != 2'd0);

    vrt_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vrt_tick_engine u_tick_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .kind          (s_kind),
        .time_ms       (s_time_ms),
        .requested_mhz (s_requested_mhz),
        .readback_word (s_readback_word),
        .rssi_sample   (s_rssi_sample),
        .cfg           (cfg),
        .burst         (burst)
    );

    vrt_result_queue u_result_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .burst    (burst),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .head     (head),
        .last     (m_last_of_run)
    );

    assign m_result_type   = head.result_type;
    assign m_frame_address = head.frame_address;
    assign m_frame_write   = head.frame_write;
    assign m_frame_data    = head.frame_data;
    assign m_verify_ok     = head.verify_ok;
    assign m_rssi_level    = head.rssi_level;

endmodule

// ===== rtl/core/vrt_cfg_regs.sv =====
// APB-style configuration registers: bus gap, tune wait, power-down frequency.
// Depends on vrt_pkg.
module vrt_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vrt_pkg::AddrWidth-1:0]  paddr,
    input  logic [vrt_pkg::DataWidth-1:0]  pwdata,
    output logic [vrt_pkg::DataWidth-1:0]  prdata,
    output logic                           pready,
    output vrt_pkg::vrt_cfg_t              cfg
);
    import vrt_pkg::*;

    vrt_cfg_t     cfg_reg;
    vrt_reg_idx_t reg_idx;
    logic         wr_en;

    assign pready  = 1'b1;
    assign reg_idx = vrt_reg_idx_t'(paddr[AddrWidth-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bus_gap_ms     <= BusGapReset;
            cfg_reg.tune_wait_ms   <= TuneWaitReset;
            cfg_reg.power_down_mhz <= PwrDownReset;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BUS_GAP:   cfg_reg.bus_gap_ms     <= pwdata[15:0];
                REG_TUNE_WAIT: cfg_reg.tune_wait_ms   <= pwdata[15:0];
                REG_PWR_DOWN:  cfg_reg.power_down_mhz <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BUS_GAP:   prdata = {16'd0, cfg_reg.bus_gap_ms};
            REG_TUNE_WAIT: prdata = {16'd0, cfg_reg.tune_wait_ms};
            REG_PWR_DOWN:  prdata = {19'd0, cfg_reg.power_down_mhz};
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/vrt_tick_engine.sv =====
// Tuner control state and per-request decode into a burst of up to three results.
// Depends on vrt_pkg.
module vrt_tick_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [1:0]           kind,
    input  logic [31:0]          time_ms,
    input  logic [12:0]          requested_mhz,
    input  logic [15:0]          readback_word,
    input  logic [11:0]          rssi_sample,
    input  vrt_pkg::vrt_cfg_t    cfg,
    output vrt_pkg::vrt_burst_t  burst
);
    import vrt_pkg::*;

    logic [12:0] current_mhz_reg,  current_mhz_next;
    logic [31:0] last_set_ms_reg,  last_set_ms_next;
    logic        tune_pending_reg, tune_pending_next;
    logic        powered_down_reg, powered_down_next;

    logic [31:0] elapsed;
    logic        is_tick, set_go, pd_req, wake, read_go;
    vrt_result_t res_freq, res_pwr_down, res_reset, res_setup, res_read;
    vrt_result_t res_verify, res_rssi;
    logic [7:0]  rssi_lvl;

    assign elapsed = time_ms - last_set_ms_reg;
    assign is_tick = (vrt_kind_t'(kind) == KIND_TICK);
    assign set_go  = is_tick && (requested_mhz != current_mhz_reg)
                     && (elapsed > {16'd0, cfg.bus_gap_ms});
    assign pd_req  = (requested_mhz == cfg.power_down_mhz);
    assign wake    = powered_down_reg && !pd_req;
    // A set in this tick restarts the timer, so no read can follow it.
    assign read_go = is_tick && !set_go && tune_pending_reg
                     && (elapsed > {16'd0, cfg.tune_wait_ms});

    assign rssi_lvl = tune_pending_reg ? 8'd0
                    : (rssi_sample[11] ? 8'hFF : rssi_sample[10:3]);

    always_comb begin
        res_freq      = '0;
        res_freq.result_type   = RES_FRAME;
        res_freq.frame_address = AddrFreq;
        res_freq.frame_write   = 1'b1;
        res_freq.frame_data    = {4'd0, freq_reg_value(requested_mhz)};

        res_pwr_down  = '0;
        res_pwr_down.result_type   = RES_FRAME;
        res_pwr_down.frame_address = AddrPower;
        res_pwr_down.frame_write   = 1'b1;
        res_pwr_down.frame_data    = PwrDownBits;

        res_reset     = '0;
        res_reset.result_type   = RES_FRAME;
        res_reset.frame_address = AddrReset;
        res_reset.frame_write   = 1'b1;

        res_setup     = '0;
        res_setup.result_type   = RES_FRAME;
        res_setup.frame_address = AddrPower;
        res_setup.frame_write   = 1'b1;
        res_setup.frame_data    = PwrSetupBits;

        res_read      = '0;
        res_read.result_type   = RES_FRAME;
        res_read.frame_address = AddrFreq;

        res_verify    = '0;
        res_verify.result_type = RES_VERIFY;
        res_verify.verify_ok   = (readback_word == freq_reg_value(current_mhz_reg));

        res_rssi      = '0;
        res_rssi.result_type   = RES_RSSI;
        res_rssi.rssi_level    = rssi_lvl;
    end

    always_comb begin
        burst = '0;
        case (vrt_kind_t'(kind))
            KIND_TICK: begin
                if (set_go && pd_req) begin
                    burst.count   = 2'd1;
                    burst.item[0] = res_pwr_down;
                end else if (set_go && wake) begin
                    burst.count   = 2'd3;
                    burst.item[0] = res_reset;
                    burst.item[1] = res_setup;
                    burst.item[2] = res_freq;
                end else if (set_go) begin
                    burst.count   = 2'd1;
                    burst.item[0] = res_freq;
                end else if (read_go) begin
                    burst.count   = 2'd1;
                    burst.item[0] = res_read;
                end
            end
            KIND_READBACK: begin
                burst.count   = 2'd1;
                burst.item[0] = res_verify;
            end
            KIND_RSSI: begin
                burst.count   = 2'd1;
                burst.item[0] = res_rssi;
            end
            default: ;
        endcase
    end

    always_comb begin
        current_mhz_next  = current_mhz_reg;
        last_set_ms_next  = last_set_ms_reg;
        tune_pending_next = tune_pending_reg;
        powered_down_next = powered_down_reg;
        if (accept && set_go) begin
            current_mhz_next = requested_mhz;
            last_set_ms_next = time_ms;
            if (pd_req) begin
                powered_down_next = 1'b1;
            end else begin
                powered_down_next = 1'b0;
                tune_pending_next = 1'b1;
            end
        end else if (accept && read_go) begin
            last_set_ms_next  = time_ms;
            tune_pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_mhz_reg  <= '0;
            last_set_ms_reg  <= '0;
            tune_pending_reg <= 1'b0;
            powered_down_reg <= 1'b0;
        end else begin
            current_mhz_reg  <= current_mhz_next;
            last_set_ms_reg  <= last_set_ms_next;
            tune_pending_reg <= tune_pending_next;
            powered_down_reg <= powered_down_next;
        end
    end

endmodule

// ===== rtl/core/vrt_result_queue.sv =====
// Result register: holds one burst of up to three results and drains it in order.
// Depends on vrt_pkg.
module vrt_result_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  vrt_pkg::vrt_burst_t  burst,
    output logic                 can_load,
    output logic                 m_valid,
    input  logic                 m_ready,
    output vrt_pkg::vrt_result_t head,
    output logic                 last
);
    import vrt_pkg::*;

    logic [1:0]        count_reg, count_next;
    vrt_result_t [2:0] slot_reg;
    logic              pop;

    assign m_valid  = (count_reg != 2'd0);
    assign pop      = m_valid && m_ready;
    // Take a new burst once the current one is gone or its final result leaves now.
    assign can_load = (count_reg == 2'd0) || ((count_reg == 2'd1) && pop);
    assign head     = slot_reg[0];
    assign last     = (count_reg == 2'd1);

    always_comb begin
        count_next = count_reg;
        if (load) begin
            count_next = burst.count;
        end else if (pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= burst.item;
        end else if (pop) begin
            // advance the remaining results toward the head
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule
